### sv/mrrd_pkg.sv
// Shared types, codes and constants of the meter reply record deframer.
// Used by every module of the block; depends on nothing.
package mrrd_pkg;

    localparam int MAX_CHANNEL_COUNT = 8;
    localparam int CHAN_IDX_W        = 3;
    localparam int CHAN_CNT_W        = 4;
    localparam int CODES_W           = 8 * MAX_CHANNEL_COUNT;

    localparam logic [7:0] PREFIX_LEAD  = 8'h21;
    localparam logic [7:0] PREFIX_FILL  = 8'h00;
    localparam logic [7:0] PREFIX_TAIL  = 8'h01;
    localparam logic [2:0] PREFIX_LAST  = 3'd4;
    localparam logic [2:0] REC_LAST_POS = 3'd6;   // record is 7 bytes
    localparam logic [2:0] REC_UNIT_POS = 3'd4;

    localparam logic [7:0] UNIT_TEMP     = 8'd1;
    localparam logic [7:0] UNIT_HUMIDITY = 8'd3;
    localparam logic [7:0] UNIT_WIND     = 8'd5;
    localparam logic [7:0] UNIT_PRESSURE = 8'd24;

    typedef enum logic [2:0] {
        KIND_RECORD    = 3'd0,
        KIND_BAD_PFX   = 3'd1,
        KIND_TOO_MANY  = 3'd2,
        KIND_BAD_UNIT  = 3'd3,
        KIND_NO_CHAN   = 3'd4,
        KIND_FRAME_END = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        QTY_TEMP     = 2'd0,
        QTY_HUMIDITY = 2'd1,
        QTY_WIND     = 2'd2,
        QTY_PRESSURE = 2'd3
    } t_qty;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_IGNORE  = 3'd1,
        PH_COUNT   = 3'd2,
        PH_RECORD  = 3'd3,
        PH_TRAILER = 3'd4
    } t_phase;

    typedef struct packed {
        logic                  found;
        logic [CHAN_IDX_W-1:0] index;
    } t_match;

    typedef struct packed {
        t_kind                 kind;
        logic [31:0]           value_bits;
        t_qty                  quantity;
        logic [CHAN_IDX_W-1:0] channel_index;
        logic [7:0]            unit_code;
        logic                  frame_last;
    } t_result;

    typedef struct packed {
        logic ok;
        t_qty qty;
    } t_unit_class;

    // Expected prefix byte at a hunt position.
    function automatic logic [7:0] prefix_byte(input logic [2:0] pos);
        logic [7:0] b;
        b = PREFIX_FILL;
        if (pos == 3'd0) b = PREFIX_LEAD;
        else if (pos == PREFIX_LAST) b = PREFIX_TAIL;
        return b;
    endfunction

    // Map a unit code to its quantity class.
    function automatic t_unit_class unit_class(input logic [7:0] unit);
        t_unit_class c;
        c.ok  = 1'b1;
        c.qty = QTY_TEMP;
        if (unit == UNIT_TEMP) c.qty = QTY_TEMP;
        else if (unit == UNIT_HUMIDITY) c.qty = QTY_HUMIDITY;
        else if (unit == UNIT_WIND) c.qty = QTY_WIND;
        else if (unit == UNIT_PRESSURE) c.qty = QTY_PRESSURE;
        else c.ok = 1'b0;
        return c;
    endfunction

endpackage

### sv/mrrd_chan_match.sv
// Channel lookup: first configured channel whose unit code matches.
// Depends on mrrd_pkg.
module mrrd_chan_match
    import mrrd_pkg::*;
(
    input  logic [7:0]            i_unit,
    input  logic [CHAN_CNT_W-1:0] i_channel_count,
    input  logic [CODES_W-1:0]    i_channel_unit_codes,
    output t_match                o_match
);

    logic [CHAN_CNT_W-1:0] limit;

    always_comb begin
        // clamp count to the channel limit
        limit = (i_channel_count > CHAN_CNT_W'(MAX_CHANNEL_COUNT))
              ? CHAN_CNT_W'(MAX_CHANNEL_COUNT) : i_channel_count;
        o_match.found = 1'b0;
        o_match.index = '0;
        for (int k = 0; k < MAX_CHANNEL_COUNT; k++) begin
            if (!o_match.found && (CHAN_CNT_W'(k) < limit)
                && (i_channel_unit_codes[8*k +: 8] == i_unit)) begin
                o_match.found = 1'b1;
                o_match.index = CHAN_IDX_W'(k);
            end
        end
    end

endmodule

### sv/mrrd_core.sv
// Frame state machine: prefix hunt, count, record assembly, trailer.
// Depends on mrrd_pkg; takes the channel match for the latched unit.
module mrrd_core
    import mrrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_match     i_match,
    output logic [7:0] o_unit,
    output logic       o_has_result,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_unit, n_unit;
    logic        r_skip, n_skip;
    t_unit_class uc;
    logic [2:0]  hpos;

    assign o_unit = r_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_left  <= '0;
            r_acc   <= '0;
            r_unit  <= '0;
            r_skip  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_unit  <= n_unit;
            r_skip  <= n_skip;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_left       = r_left;
        n_acc        = r_acc;
        n_unit       = r_unit;
        n_skip       = r_skip;
        o_has_result = 1'b0;
        o_result     = '0;
        uc           = unit_class(r_unit);
        hpos         = (r_pos > PREFIX_LAST) ? 3'd0 : r_pos;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == prefix_byte(hpos)) begin
                    if (hpos == PREFIX_LAST) begin
                        n_phase = PH_IGNORE;
                        n_pos   = '0;
                    end else begin
                        n_pos = hpos + 3'd1;
                    end
                end else begin
                    // resync: a lead byte restarts the prefix at its second byte
                    n_pos                = (i_byte == PREFIX_LEAD) ? 3'd1 : 3'd0;
                    o_has_result         = 1'b1;
                    o_result.kind        = KIND_BAD_PFX;
                    o_result.frame_last  = 1'b1;
                end
            end
            PH_IGNORE: begin
                n_phase = PH_COUNT;
            end
            PH_COUNT: begin
                n_left  = i_byte;
                n_pos   = '0;
                n_skip  = 1'b0;
                n_phase = (i_byte == 8'd0) ? PH_TRAILER : PH_RECORD;
                if (i_byte > 8'(MAX_CHANNEL_COUNT)) begin
                    n_skip               = 1'b1;
                    o_has_result         = 1'b1;
                    o_result.kind        = KIND_TOO_MANY;
                    o_result.frame_last  = 1'b1;
                end
            end
            PH_RECORD: begin
                if (r_pos < REC_UNIT_POS) begin
                    if (r_pos == 3'd0) n_acc = {24'd0, i_byte};
                    else n_acc[8*r_pos[1:0] +: 8] = i_byte;
                    n_pos = r_pos + 3'd1;
                end else if (r_pos == REC_UNIT_POS) begin
                    n_unit = i_byte;
                    n_pos  = r_pos + 3'd1;
                end else if (r_pos < REC_LAST_POS) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_pos  = '0;
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) n_phase = PH_TRAILER;
                    if (!r_skip) begin
                        o_has_result        = 1'b1;
                        o_result.value_bits = r_acc;
                        o_result.unit_code  = r_unit;
                        if (!uc.ok) begin
                            n_skip              = 1'b1;
                            o_result.kind       = KIND_BAD_UNIT;
                            o_result.frame_last = 1'b1;
                        end else if (!i_match.found) begin
                            n_skip              = 1'b1;
                            o_result.kind       = KIND_NO_CHAN;
                            o_result.quantity   = uc.qty;
                            o_result.frame_last = 1'b1;
                        end else begin
                            o_result.kind          = KIND_RECORD;
                            o_result.quantity      = uc.qty;
                            o_result.channel_index = i_match.index;
                        end
                    end
                end
            end
            PH_TRAILER: begin
                if (r_pos == 3'd0) begin
                    n_acc = {24'd0, i_byte};
                    n_pos = 3'd1;
                end else begin
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                    if (r_skip) begin
                        n_skip = 1'b0;
                    end else begin
                        o_has_result        = 1'b1;
                        o_result.kind       = KIND_FRAME_END;
                        o_result.value_bits = {16'd0, i_byte, r_acc[7:0]};
                        o_result.frame_last = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_pos   = '0;
                n_skip  = 1'b0;
            end
        endcase
    end

endmodule

### sv/meter_reply_record_deframer.sv
// Top level of the meter reply record deframer: APB registers, input and
// result registers around the frame core. Depends on mrrd_pkg, mrrd_core
// and mrrd_chan_match.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_byte) carries one reply
//   word per handshake: a byte of the reply with link headers removed.
//   Output channel (o_out_valid / i_out_ready) carries one result word per
//   record, error or frame end (none for the rest of a frame after an error):
//   kind, value bits, quantity, channel index, unit code and a frame_last flag.
//   A result passes through the input register, which takes the closing
//   byte, and then through the result register.
//   Throughput: one byte per cycle while the input register is not stalled;
//   the core takes the next byte while a result waits in the result reg.
//   Stall: when the receiver holds i_out_ready low and the result register
//   is full, a byte that would make a result waits in the input register,
//   and o_in_ready drops; bytes that make no result keep flowing.
//   Reset (synchronous, active low): the core returns to prefix hunting,
//   both registers empty, channel_count and channel_unit_codes cleared.
//   Registers: channel_count at 0x0, channel_unit_codes at 0x8; write
//   only while the block is idle.
module meter_reply_record_deframer
    import mrrd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    // input words
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    // result words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_kind,
    output logic [31:0]           o_value_bits,
    output logic [1:0]            o_quantity,
    output logic [CHAN_IDX_W-1:0] o_channel_index,
    output logic [7:0]            o_unit_code,
    output logic                  o_frame_last
);

    logic [CHAN_CNT_W-1:0] r_channel_count;
    logic [CODES_W-1:0]    r_channel_unit_codes;
    logic                  cfg_wr;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  out_free;
    logic                  step;
    logic                  has_result;
    t_result               result;
    t_match                match;
    logic [7:0]            unit;

    // Configuration registers: address bit 3 picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count      <= '0;
            r_channel_unit_codes <= '0;
        end else if (cfg_wr) begin
            if (paddr[3]) r_channel_unit_codes <= pwdata;
            else r_channel_count <= pwdata[CHAN_CNT_W-1:0];
        end
    end

    assign prdata = paddr[3] ? r_channel_unit_codes
                             : {{(64-CHAN_CNT_W){1'b0}}, r_channel_count};

    // Advance the held byte unless it makes a result that has nowhere to go
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!has_result || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_byte <= i_in_byte;
    end

    mrrd_chan_match u_match (
        .i_unit               (unit),
        .i_channel_count      (r_channel_count),
        .i_channel_unit_codes (r_channel_unit_codes),
        .o_match              (match)
    );

    mrrd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_match      (match),
        .o_unit       (unit),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Result register: load a new result, else drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_result) r_out <= result;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_value_bits    = r_out.value_bits;
    assign o_quantity      = r_out.quantity;
    assign o_channel_index = r_out.channel_index;
    assign o_unit_code     = r_out.unit_code;
    assign o_frame_last    = r_out.frame_last;

endmodule
